// ===== rtl/tlpt_pkg.sv =====
// Shared types, field layouts and constants of the two-level page table engine.
package tlpt_pkg;

  localparam int ADDR_W         = 32;
  localparam int FLAGS_W        = 12;
  localparam int IDX_W          = 10;
  localparam int OFS_W          = 12;
  localparam int DIR_ENTRIES    = 1 << IDX_W;
  localparam int TBL_ENTRIES    = 1 << IDX_W;
  localparam int TABLE_POOL_DEF = 16;

  // Directory entry bit positions; the pool slot sits above the flag bits
  localparam int DE_PRESENT  = 0;
  localparam int DE_WRITE    = 1;
  localparam int DE_USER     = 2;
  localparam int DE_SLOT_LSB = 3;

  // Page flag that is copied into a freshly made directory entry
  localparam int FLAG_USER = 2;

  // Table entry word: frame in 31:12, flags in 11:1, present mark in bit 0
  localparam int PTE_W       = 32;
  localparam int PTE_PRESENT = 0;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_NO_TABLE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIR,
    S_ENT
  } state_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [ADDR_W-1:0]    vaddr;
    logic [ADDR_W-1:0]    paddr;
    logic [FLAGS_W-1:0]   page_flags;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_out;
    status_t           status;
  } rsp_t;

  // Memory port strobes from the sequencer to the table store
  typedef struct packed {
    logic dir_rd;
    logic dir_wr;
    logic ent_rd;
    logic ent_wr;
  } mem_ctl_t;

endpackage

// ===== rtl/two_level_page_table_engine.sv =====
// Result: registered after the directory read of the accepted item; a translate hitting
// a present directory slot adds a second, dependent read of the table entry memory.
// Throughput: one item per cycle while the result register is free or taken; such a translate
// holds the next item until its entry read is done. Output register lets the next item enter.
// Reset: control clears at once, then a sweep zeroes both memories, all TABLE_POOL*1024
// table entries (16384 by default); req_ready stays low until it ends.
module two_level_page_table_engine import tlpt_pkg::*; #(
  parameter int TABLE_POOL = TABLE_POOL_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int DE_W      = DE_SLOT_LSB + SLOT_W;
  localparam int ENT_DEPTH = TABLE_POOL * TBL_ENTRIES;
  localparam int ENT_AW    = $clog2(ENT_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_POOL + 1);

  state_t            state;
  state_t            state_next;
  req_t              item;
  logic [CNT_W-1:0]  next_free;
  logic              rsp_load;
  rsp_t              rsp_next;

  mem_ctl_t          ctl;
  logic [DE_W-1:0]   dir_rdata;
  logic [DE_W-1:0]   dir_wdata;
  logic [ENT_AW-1:0] ent_addr;
  logic [PTE_W-1:0]  ent_wdata;
  logic [PTE_W-1:0]  ent_rdata;
  logic              clearing;

  logic              accept;
  logic              out_free;
  logic              de_present;
  logic              pool_full;
  logic [DE_W-1:0]   new_de;
  logic [DE_W-1:0]   use_de;
  logic              need_ent;
  logic [IDX_W-1:0]  tix;

  tlpt_store #(
    .TABLE_POOL(TABLE_POOL)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .dir_raddr (req.vaddr[ADDR_W-1 -: IDX_W]),
    .dir_waddr (item.vaddr[ADDR_W-1 -: IDX_W]),
    .dir_wdata (dir_wdata),
    .dir_rdata (dir_rdata),
    .ent_addr  (ent_addr),
    .ent_wdata (ent_wdata),
    .ent_rdata (ent_rdata),
    .clearing  (clearing)
  );

  assign accept   = req_valid & req_ready;
  assign out_free = ~rsp_valid | rsp_ready;

  // Decode the directory entry of the item in flight
  always_comb begin
    tix        = item.vaddr[OFS_W+IDX_W-1 -: IDX_W];
    de_present = dir_rdata[DE_PRESENT];
    pool_full  = (next_free == CNT_W'(TABLE_POOL));
    new_de     = '0;
    new_de[DE_W-1:DE_SLOT_LSB] = next_free[SLOT_W-1:0];
    new_de[DE_USER]    = item.page_flags[FLAG_USER];
    new_de[DE_WRITE]   = 1'b1;
    new_de[DE_PRESENT] = 1'b1;
    use_de     = de_present ? dir_rdata : new_de;
    ent_addr   = ENT_AW'({use_de[DE_W-1:DE_SLOT_LSB], tix});
    need_ent   = (item.cmd == CMD_XLATE) && de_present;
    dir_wdata  = new_de;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DIR;
      end
      S_DIR: begin
        if (need_ent) begin
          state_next = S_ENT;
        end else if (out_free) begin
          state_next = accept ? S_DIR : S_IDLE;
        end
      end
      S_ENT: begin
        if (out_free) state_next = accept ? S_DIR : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory strobes, handshake and result
  always_comb begin
    ctl       = '0;
    req_ready = 1'b0;
    rsp_load  = 1'b0;
    rsp_next  = '{phys_out: '0, status: ST_DONE};
    ent_wdata = '0;
    case (state)
      S_IDLE: begin
        req_ready = ~clearing;
      end
      S_DIR: begin
        if (need_ent) begin
          ctl.ent_rd = 1'b1;
        end else if (out_free) begin
          req_ready = 1'b1;
          rsp_load  = 1'b1;
          case (item.cmd)
            CMD_MAP: begin
              if (!de_present && pool_full) begin
                rsp_next.status = ST_NO_TABLE;
              end else begin
                ctl.dir_wr = ~de_present;
                ctl.ent_wr = 1'b1;
                ent_wdata  = {item.paddr[ADDR_W-1:OFS_W],
                              item.page_flags[FLAGS_W-1:1], 1'b1};
              end
            end
            CMD_UNMAP: begin
              ctl.ent_wr = de_present;
            end
            CMD_XLATE: begin
              rsp_next.status = ST_NOT_MAPPED;
            end
            default: begin
              rsp_next.status = ST_DONE;
            end
          endcase
        end
      end
      S_ENT: begin
        if (out_free) begin
          req_ready = 1'b1;
          rsp_load  = 1'b1;
          if (ent_rdata[PTE_PRESENT]) begin
            rsp_next.phys_out = {ent_rdata[PTE_W-1:OFS_W], item.vaddr[OFS_W-1:0]};
          end else begin
            rsp_next.status = ST_NOT_MAPPED;
          end
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
    if (accept) ctl.dir_rd = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      next_free <= '0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_load | (rsp_valid & ~rsp_ready);
      if (ctl.dir_wr) next_free <= next_free + 1'b1;
    end
  end

  // Hold the accepted item and the pending result
  always_ff @(posedge clk) begin
    if (accept) item <= req;
    if (rsp_load) rsp <= rsp_next;
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= CNT_W'(TABLE_POOL))
    else $error("table pool counter ran past the pool size");

  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    ctl.dir_wr |=> next_free == $past(next_free) + 1'b1)
    else $error("directory allocation did not advance the pool counter");

  a_rsp_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || rsp_ready))
    else $error("result loaded over an untaken result");

  a_accept_dir: assert property (@(posedge clk) disable iff (rst)
    accept |-> !clearing ##1 state == S_DIR)
    else $error("accepted item did not enter the directory lookup");

endmodule

// ===== rtl/tlpt_store.sv =====
// Directory and table entry memories with reset sweep and directory write bypass.
module tlpt_store import tlpt_pkg::*; #(
  parameter int TABLE_POOL = TABLE_POOL_DEF,
  localparam int SLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1,
  localparam int DE_W      = DE_SLOT_LSB + SLOT_W,
  localparam int ENT_DEPTH = TABLE_POOL * TBL_ENTRIES,
  localparam int ENT_AW    = $clog2(ENT_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  mem_ctl_t          ctl,
  input  logic [IDX_W-1:0]  dir_raddr,
  input  logic [IDX_W-1:0]  dir_waddr,
  input  logic [DE_W-1:0]   dir_wdata,
  output logic [DE_W-1:0]   dir_rdata,
  input  logic [ENT_AW-1:0] ent_addr,
  input  logic [PTE_W-1:0]  ent_wdata,
  output logic [PTE_W-1:0]  ent_rdata,
  output logic              clearing
);

  logic [DE_W-1:0]   dir_mem [DIR_ENTRIES];
  logic [PTE_W-1:0]  ent_mem [ENT_DEPTH];

  logic [ENT_AW-1:0] clr_cnt;
  logic [DE_W-1:0]   dir_q;
  logic [IDX_W-1:0]  dir_raddr_q;

  logic              byp_valid;
  logic [IDX_W-1:0]  byp_addr;
  logic [DE_W-1:0]   byp_data;

  logic              dir_we;
  logic [IDX_W-1:0]  dir_wa;
  logic [DE_W-1:0]   dir_wd;
  logic              ent_we;
  logic [ENT_AW-1:0] ent_wa;
  logic [PTE_W-1:0]  ent_wd;

  // Sweep both memories to zero after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == ENT_AW'(ENT_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Steer write ports between the sweep and item writes
  always_comb begin
    dir_we = clearing | ctl.dir_wr;
    dir_wa = clearing ? clr_cnt[IDX_W-1:0] : dir_waddr;
    dir_wd = clearing ? '0 : dir_wdata;
    ent_we = clearing | ctl.ent_wr;
    ent_wa = clearing ? clr_cnt : ent_addr;
    ent_wd = clearing ? '0 : ent_wdata;
  end

  // Directory memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    if (ctl.dir_rd) begin
      dir_q       <= dir_mem[dir_raddr];
      dir_raddr_q <= dir_raddr;
    end
  end

  // Table entry memory: single address, registered read
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ctl.ent_rd) begin
      ent_rdata <= ent_mem[ent_addr];
    end
  end

  // Remember the last item write to the directory; it covers a read issued on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (ctl.dir_wr) begin
      byp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dir_wr) begin
      byp_addr <= dir_waddr;
      byp_data <= dir_wdata;
    end
  end

  assign dir_rdata = (byp_valid && byp_addr == dir_raddr_q) ? byp_data : dir_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the two-level page table engine: map, unmap and translate items.
module testbench;
  import tlpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL        = TABLE_POOL_DEF;
  localparam int RAND_ITEMS  = 1500;
  localparam int IDLE_LIMIT  = 60000;   // covers the post-reset memory sweep several times
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_REPORTS = 40;
  localparam int DIR_CHOICES = 24;      // more directory slots than the pool can back
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  two_level_page_table_engine #(.TABLE_POOL(POOL)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Shadow copy of the directory, table pool and allocator
  bit          dir_on   [DIR_ENTRIES];
  int unsigned dir_slot [DIR_ENTRIES];
  bit          pte_on   [POOL*TBL_ENTRIES];
  bit [31:0]   pte_word [POOL*TBL_ENTRIES];
  int unsigned free_table = 0;

  req_t req_backlog[$];
  rsp_t walk_results_q[$];

  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_maps = 0, n_unmaps = 0, n_hits = 0, n_misses = 0, n_dropped = 0, n_reserved = 0;

  // Apply one item to the shadow tables and return the result it should produce
  function automatic rsp_t walk_page_table(req_t r);
    logic [IDX_W-1:0] dix;
    logic [IDX_W-1:0] tix;
    int unsigned pos;
    rsp_t res;
    dix = r.vaddr[31:22];
    tix = r.vaddr[21:12];
    res.phys_out = '0;
    res.status   = ST_DONE;
    case (r.cmd)
      CMD_MAP: begin
        n_maps++;
        if (!dir_on[dix] && free_table < POOL) begin
          dir_on[dix]   = 1'b1;
          dir_slot[dix] = free_table;
          free_table++;
        end
        if (dir_on[dix]) begin
          pos = dir_slot[dix] * TBL_ENTRIES + tix;
          pte_word[pos] = {r.paddr[31:12], r.page_flags[11:1], 1'b0};
          pte_on[pos]   = 1'b1;
        end else begin
          res.status = ST_NO_TABLE;
          n_dropped++;
        end
      end
      CMD_UNMAP: begin
        n_unmaps++;
        if (dir_on[dix]) begin
          pos = dir_slot[dix] * TBL_ENTRIES + tix;
          pte_word[pos] = '0;
          pte_on[pos]   = 1'b0;
        end
      end
      CMD_XLATE: begin
        res.status = ST_NOT_MAPPED;
        if (dir_on[dix]) begin
          pos = dir_slot[dix] * TBL_ENTRIES + tix;
          if (pte_on[pos]) begin
            res.phys_out = {pte_word[pos][31:12], r.vaddr[11:0]};
            res.status   = ST_DONE;
          end
        end
        if (res.status == ST_DONE) n_hits++;
        else n_misses++;
      end
      default: n_reserved++;
    endcase
    return res;
  endfunction

  task automatic queue_item(logic [1:0] code, logic [31:0] va, logic [31:0] pa,
                            logic [11:0] flags);
    req_t r;
    r.cmd        = cmd_t'(code);
    r.vaddr      = va;
    r.paddr      = pa;
    r.page_flags = flags;
    req_backlog.push_back(r);
  endtask

  // Clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Request driver: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (req_valid && req_ready) begin
        walk_results_q.push_back(walk_page_table(req));
        n_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req       <= req_backlog.pop_front();
          req_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response ready follows a rotating stall pattern that is redrawn now and then
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  pat_pos   = '0;
  int          pat_age   = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      pat_age   = 0;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(32, 256);
        if ($urandom_range(0, 3) == 0) stall_pat = 16'hFFFF;
        else stall_pat = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
      end
      pat_age--;
      rsp_ready <= stall_pat[pat_pos];
      pat_pos   = pat_pos + 4'd1;
    end
  end

  // Result monitor: compare each item against the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (walk_results_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected result item phys_out=%h status=%0d",
                   $realtime, rsp.phys_out, rsp.status);
      end else begin
        exp_rsp = walk_results_q.pop_front();
        n_checked++;
        if (rsp.phys_out !== exp_rsp.phys_out) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: phys_out mismatch on result %0d: expected %h, got %h",
                     $realtime, n_checked, exp_rsp.phys_out, rsp.phys_out);
        end
        if (rsp.status !== exp_rsp.status) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: status mismatch on result %0d: expected %0d, got %0d",
                     $realtime, n_checked, exp_rsp.status, rsp.status);
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles, %0d results still expected",
             $realtime, IDLE_LIMIT, walk_results_q.size());
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [9:0]  dir_pick [DIR_CHOICES];
    int unsigned mapped_pages[$];
    logic [31:0] va;
    logic [9:0]  tix;
    int          sel;

    // Directed: empty table, reserved command, field extremes, overwrite, unmap cases
    queue_item(CMD_XLATE,    32'h0000_0000, 32'h0000_0000, 12'h000);
    queue_item(CMD_UNMAP,    32'h0000_0000, 32'h0000_0000, 12'h000);
    queue_item(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    queue_item(CMD_MAP,      32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
    queue_item(CMD_XLATE,    32'h0000_0FFF, 32'h0000_0000, 12'h000);
    queue_item(CMD_RESERVED, 32'h0000_0000, 32'h0000_0000, 12'h000);
    queue_item(CMD_XLATE,    32'h0000_0000, 32'h0000_0000, 12'h000);
    queue_item(CMD_MAP,      32'h0000_0000, 32'h1234_5FFF, 12'h000);
    queue_item(CMD_XLATE,    32'h0000_0ABC, 32'hFFFF_FFFF, 12'hFFF);
    queue_item(CMD_MAP,      32'hFFFF_FFFF, 32'h0000_0000, 12'h004);
    queue_item(CMD_XLATE,    32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
    queue_item(CMD_XLATE,    32'hFFFF_E000, 32'h0000_0000, 12'h000);
    queue_item(CMD_UNMAP,    32'hFFFF_F000, 32'h0000_0000, 12'h000);
    queue_item(CMD_XLATE,    32'hFFFF_F123, 32'h0000_0000, 12'h000);
    queue_item(CMD_UNMAP,    32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFF);
    queue_item(CMD_MAP,      32'hFFFF_F000, 32'h5A5A_5000, 12'h555);
    queue_item(CMD_XLATE,    32'hFFFF_F800, 32'h0000_0000, 12'h000);
    queue_item(CMD_MAP,      32'h0040_0000, 32'hA5A5_A000, 12'hAAA);
    queue_item(CMD_XLATE,    32'h0040_0555, 32'h0000_0000, 12'h000);
    queue_item(CMD_XLATE,    32'h0040_1555, 32'h0000_0000, 12'h000);
    queue_item(CMD_UNMAP,    32'h0080_0000, 32'h0000_0000, 12'h000);

    // Random: a limited set of directory slots, so the pool runs dry part way through
    dir_pick[0] = 10'd0;
    dir_pick[1] = 10'd1;
    dir_pick[2] = 10'd1023;
    dir_pick[3] = 10'd512;
    for (int i = 4; i < DIR_CHOICES; i++) dir_pick[i] = 10'($urandom_range(0, 1023));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       tix = 10'($urandom);
        1:       tix = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
        default: tix = 10'($urandom_range(0, 7));
      endcase
      va = {dir_pick[$urandom_range(0, DIR_CHOICES-1)], tix, 12'($urandom)};
      if (sel < 5) begin
        queue_item(CMD_RESERVED, $urandom, $urandom, 12'($urandom));
      end else if (sel < 10) begin
        queue_item(CMD_MAP, $urandom, $urandom, 12'($urandom));
      end else if (sel < 42) begin
        queue_item(CMD_MAP, va, $urandom, 12'($urandom));
        mapped_pages.push_back(va);
        if (mapped_pages.size() > 64) void'(mapped_pages.pop_front());
      end else if (sel < 54) begin
        if (mapped_pages.size() > 0 && $urandom_range(0, 2) != 0)
          va = mapped_pages[$urandom_range(0, mapped_pages.size()-1)];
        queue_item(CMD_UNMAP, va, $urandom, 12'($urandom));
      end else begin
        if (mapped_pages.size() > 0 && $urandom_range(0, 3) != 0)
          va = {mapped_pages[$urandom_range(0, mapped_pages.size()-1)][31:12],
                12'($urandom)};
        else if ($urandom_range(0, 3) == 0)
          va = $urandom;
        queue_item(CMD_XLATE, va, $urandom, 12'($urandom));
      end
    end

    // Drain: all items sent, all results back, then a short settle
    while (req_backlog.size() != 0 || req_valid) @(posedge clk);
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    n_errors += walk_results_q.size();

    $display("Covered %0d items (%0d checked): %0d maps, %0d dropped for lack of a table,",
             n_accepted, n_checked, n_maps, n_dropped);
    $display("%0d unmaps; translations: %0d hits, %0d misses; %0d reserved; %0d tables used",
             n_unmaps, n_hits, n_misses, n_reserved, free_table);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
